[rtl/core/empirical_vus_three_class_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the three-class VUS core.
// Shared wrappers around clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef EMPIRICAL_VUS_THREE_CLASS_CORE_ASSERT_SVH
`define EMPIRICAL_VUS_THREE_CLASS_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EVTC_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EVTC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/evtc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// evtc_pkg
// Shared types and constants of the three-class VUS core.
// ----------------------------------------------------------------------------
package evtc_pkg;

  // Input item fields.
  localparam int unsigned SCORE_W    = 32;
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned GROUP_W    = 2;
  localparam int unsigned IN_TUSER_W = ACTION_W + GROUP_W;

  // Result item fields and their places in the output tdata.
  localparam int unsigned VUS_W       = 17;
  localparam int unsigned SIXTHS_W    = 27;
  localparam int unsigned TRIPLES_W   = 25;
  localparam int unsigned VUS_LSB     = 0;
  localparam int unsigned SIXTHS_LSB  = VUS_LSB + VUS_W;
  localparam int unsigned TRIPLES_LSB = SIXTHS_LSB + SIXTHS_W;
  localparam int unsigned EMPTY_LSB   = TRIPLES_LSB + TRIPLES_W;
  localparam int unsigned OVF_LSB     = EMPTY_LSB + 1;
  localparam int unsigned OUT_BITS    = OVF_LSB + 1;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_LOAD    = 2'd1,
    ACT_COMPUTE = 2'd2
  } action_e;

  localparam logic [GROUP_W-1:0] GRP_ONE   = 2'd0;
  localparam logic [GROUP_W-1:0] GRP_TWO   = 2'd1;
  localparam logic [GROUP_W-1:0] GRP_THREE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRIP_A,
    ST_TRIP_B,
    ST_Y,
    ST_SCAN,
    ST_MUL,
    ST_ACC,
    ST_DIV_INIT,
    ST_DIV,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic trip_a;
    logic trip_b;
    logic y_issue;
    logic scan;
    logic mul;
    logic acc;
    logic div_init;
    logic div_step;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic scan_done;
    logic last_y;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

[rtl/core/evtc_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// evtc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module evtc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic                                    re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/core/evtc_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// evtc_ctrl
// Sequencer of the VUS core: walks loads, the triple scan and the division.
// ----------------------------------------------------------------------------
module evtc_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire evtc_pkg::action_e action_i,
  input  wire evtc_pkg::sts_t  sts_i,
  output evtc_pkg::cmd_t       cmd_o
);
  import evtc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (action_i == ACT_COMPUTE)) begin
          state_d = ST_TRIP_A;
        end
      end
      ST_TRIP_A:   state_d = sts_i.empty ? ST_DONE : ST_TRIP_B;
      ST_TRIP_B:   state_d = ST_Y;
      ST_Y:        state_d = ST_SCAN;
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:      state_d = ST_ACC;
      ST_ACC:      state_d = sts_i.last_y ? ST_DIV_INIT : ST_Y;
      ST_DIV_INIT: state_d = ST_DIV;
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sts_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE:     cmd_o.in_ready = 1'b1;
      ST_TRIP_A:   cmd_o.trip_a   = 1'b1;
      ST_TRIP_B:   cmd_o.trip_b   = 1'b1;
      ST_Y:        cmd_o.y_issue  = 1'b1;
      ST_SCAN:     cmd_o.scan     = 1'b1;
      ST_MUL:      cmd_o.mul      = 1'b1;
      ST_ACC:      cmd_o.acc      = 1'b1;
      ST_DIV_INIT: cmd_o.div_init = 1'b1;
      ST_DIV:      cmd_o.div_step = 1'b1;
      ST_DONE:     cmd_o.finish   = !sts_i.out_busy;
      default:     cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/evtc_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// evtc_dp
// Datapath of the VUS core: score stores, counters, products and divider.
// ----------------------------------------------------------------------------
module evtc_dp #(
  parameter int unsigned MAX_PER_GROUP = 256,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire evtc_pkg::cmd_t                       cmd_i,
  output evtc_pkg::sts_t                            sts_o,
  input  wire logic                                 in_valid_i,
  input  wire evtc_pkg::action_e                    action_i,
  input  wire logic [evtc_pkg::GROUP_W-1:0]         group_i,
  input  wire logic [evtc_pkg::SCORE_W-1:0]         score_i,
  input  wire logic                                 out_ready_i,
  output logic                                      out_valid_o,
  output logic      [evtc_pkg::OUT_TDATA_W-1:0]     out_data_o
);
  import evtc_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_PER_GROUP + 1);
  localparam int unsigned ADDR_W = (MAX_PER_GROUP > 1) ? $clog2(MAX_PER_GROUP) : 1;
  localparam int unsigned TRI_W  = 3 * CNT_W;
  localparam int unsigned SIX_W  = TRI_W + 3;
  localparam int unsigned PRD_W  = 2 * CNT_W;
  localparam int unsigned QUO_W  = FRACTION_BITS + 1;
  localparam int unsigned DC_W   = $clog2(FRACTION_BITS + 2);

  logic accept;
  assign accept = in_valid_i && cmd_i.in_ready;

  // ---------------- group counts and drop flag ----------------
  logic [CNT_W-1:0] n1_q, n2_q, n3_q, n1_d, n2_d, n3_d;
  logic             drop_q, drop_d;
  logic             we1, we2, we3;

  always_comb begin
    n1_d   = n1_q;
    n2_d   = n2_q;
    n3_d   = n3_q;
    drop_d = drop_q;
    we1    = 1'b0;
    we2    = 1'b0;
    we3    = 1'b0;
    if (accept) begin
      unique case (action_i)
        ACT_CLEAR: begin
          n1_d   = '0;
          n2_d   = '0;
          n3_d   = '0;
          drop_d = 1'b0;
        end
        ACT_LOAD: begin
          unique case (group_i)
            GRP_ONE: begin
              if (n1_q == CNT_W'(MAX_PER_GROUP)) begin
                drop_d = 1'b1;
              end else begin
                we1  = 1'b1;
                n1_d = n1_q + CNT_W'(1);
              end
            end
            GRP_TWO: begin
              if (n2_q == CNT_W'(MAX_PER_GROUP)) begin
                drop_d = 1'b1;
              end else begin
                we2  = 1'b1;
                n2_d = n2_q + CNT_W'(1);
              end
            end
            GRP_THREE: begin
              if (n3_q == CNT_W'(MAX_PER_GROUP)) begin
                drop_d = 1'b1;
              end else begin
                we3  = 1'b1;
                n3_d = n3_q + CNT_W'(1);
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // ---------------- scan control ----------------
  logic [CNT_W-1:0] i_q, i_d, j_q, j_d;
  logic             v1_q, v1_d, v3_q, v3_d;
  logic             re1, re3, scan_done;
  logic [ADDR_W-1:0] raddr13;

  assign scan_done = (i_q >= n1_q) && (i_q >= n3_q);
  assign re1       = cmd_i.y_issue || (cmd_i.scan && (i_q < n1_q));
  assign re3       = cmd_i.y_issue || (cmd_i.scan && (i_q < n3_q));
  assign raddr13   = cmd_i.y_issue ? '0 : i_q[ADDR_W-1:0];

  always_comb begin
    i_d  = i_q;
    v1_d = 1'b0;
    v3_d = 1'b0;
    j_d  = j_q;
    if (cmd_i.y_issue) begin
      i_d  = CNT_W'(1);
      v1_d = 1'b1;
      v3_d = 1'b1;
    end else if (cmd_i.scan) begin
      v1_d = re1;
      v3_d = re3;
      if (!scan_done) begin
        i_d = i_q + CNT_W'(1);
      end
    end
    if (accept) begin
      j_d = '0;
    end else if (cmd_i.acc) begin
      j_d = j_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n1_q   <= '0;
      n2_q   <= '0;
      n3_q   <= '0;
      drop_q <= 1'b0;
      v1_q   <= 1'b0;
      v3_q   <= 1'b0;
      i_q    <= '0;
      j_q    <= '0;
    end else begin
      n1_q   <= n1_d;
      n2_q   <= n2_d;
      n3_q   <= n3_d;
      drop_q <= drop_d;
      v1_q   <= v1_d;
      v3_q   <= v3_d;
      i_q    <= i_d;
      j_q    <= j_d;
    end
  end

  // ---------------- score stores ----------------
  logic [SCORE_W-1:0] rd1, rd2, rd3;

  evtc_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_PER_GROUP)) u_ram_one (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (n1_q[ADDR_W-1:0]),
    .wdata_i (score_i),
    .re_i    (re1),
    .raddr_i (raddr13),
    .rdata_o (rd1)
  );

  evtc_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_PER_GROUP)) u_ram_two (
    .clk_i   (clk_i),
    .we_i    (we2),
    .waddr_i (n2_q[ADDR_W-1:0]),
    .wdata_i (score_i),
    .re_i    (cmd_i.y_issue),
    .raddr_i (j_q[ADDR_W-1:0]),
    .rdata_o (rd2)
  );

  evtc_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_PER_GROUP)) u_ram_three (
    .clk_i   (clk_i),
    .we_i    (we3),
    .waddr_i (n3_q[ADDR_W-1:0]),
    .wdata_i (score_i),
    .re_i    (re3),
    .raddr_i (raddr13),
    .rdata_o (rd3)
  );

  // ---------------- per-y tallies ----------------
  // The group two score stays on the read port for the whole scan.
  logic [CNT_W-1:0] lt_q, eqx_q, gt_q, eqz_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.y_issue) begin
      lt_q  <= '0;
      eqx_q <= '0;
      gt_q  <= '0;
      eqz_q <= '0;
    end else if (cmd_i.scan) begin
      if (v1_q) begin
        if ($signed(rd1) < $signed(rd2)) begin
          lt_q <= lt_q + CNT_W'(1);
        end else if (rd1 == rd2) begin
          eqx_q <= eqx_q + CNT_W'(1);
        end
      end
      if (v3_q) begin
        if ($signed(rd3) > $signed(rd2)) begin
          gt_q <= gt_q + CNT_W'(1);
        end else if (rd3 == rd2) begin
          eqz_q <= eqz_q + CNT_W'(1);
        end
      end
    end
  end

  // ---------------- products, accumulator, triple count ----------------
  logic [PRD_W-1:0] p_ltgt_q, p_eqxgt_q, p_lteqz_q, p_eqxeqz_q, p12_q;
  logic [TRI_W-1:0] trip_q;
  logic [SIX_W-1:0] acc_q;
  logic [SIX_W-1:0] term6, term3, pair_sum;

  assign pair_sum = SIX_W'(p_eqxgt_q) + SIX_W'(p_lteqz_q);
  assign term6    = (SIX_W'(p_ltgt_q) << 2) + (SIX_W'(p_ltgt_q) << 1);
  assign term3    = (pair_sum << 1) + pair_sum;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      p_ltgt_q   <= PRD_W'(lt_q) * PRD_W'(gt_q);
      p_eqxgt_q  <= PRD_W'(eqx_q) * PRD_W'(gt_q);
      p_lteqz_q  <= PRD_W'(lt_q) * PRD_W'(eqz_q);
      p_eqxeqz_q <= PRD_W'(eqx_q) * PRD_W'(eqz_q);
    end
    if (cmd_i.trip_a) begin
      p12_q <= PRD_W'(n1_q) * PRD_W'(n2_q);
    end
    if (cmd_i.trip_b) begin
      trip_q <= TRI_W'(p12_q) * TRI_W'(n3_q);
    end
    if (accept) begin
      acc_q <= '0;
    end else if (cmd_i.acc) begin
      acc_q <= acc_q + term6 + term3 + SIX_W'(p_eqxeqz_q);
    end
  end

  // ---------------- restoring divider ----------------
  // The first step takes the integer bit, then one fraction bit per step.
  logic [SIX_W-1:0] den_q;
  logic [SIX_W:0]   rem_q, rem_sh, rem_diff;
  logic [QUO_W-1:0] quo_q;
  logic [DC_W-1:0]  dcnt_q;
  logic             q_bit;

  assign rem_sh   = (dcnt_q == DC_W'(FRACTION_BITS + 1)) ? rem_q : (rem_q << 1);
  assign rem_diff = rem_sh - {1'b0, den_q};
  assign q_bit    = (rem_sh >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      den_q  <= (SIX_W'(trip_q) << 2) + (SIX_W'(trip_q) << 1);
      rem_q  <= {1'b0, acc_q};
      quo_q  <= '0;
      dcnt_q <= DC_W'(FRACTION_BITS + 1);
    end else if (cmd_i.div_step) begin
      rem_q  <= q_bit ? rem_diff : rem_sh;
      quo_q  <= {quo_q[QUO_W-2:0], q_bit};
      dcnt_q <= dcnt_q - DC_W'(1);
    end
  end

  // ---------------- result register ----------------
  logic                    out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0]  out_data_q;
  logic                    empty;
  logic [QUO_W+VUS_W-1:0]  quo_ext;
  logic [SIX_W+SIXTHS_W-1:0] six_ext;
  logic [TRI_W+TRIPLES_W-1:0] tri_ext;

  assign empty   = (n1_q == '0) || (n2_q == '0) || (n3_q == '0);
  assign quo_ext = {VUS_W'(0), quo_q};
  assign six_ext = {SIXTHS_W'(0), acc_q};
  assign tri_ext = {TRIPLES_W'(0), trip_q};

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_q <= '0;
      if (!empty) begin
        out_data_q[VUS_LSB +: VUS_W]         <= quo_ext[VUS_W-1:0];
        out_data_q[SIXTHS_LSB +: SIXTHS_W]   <= six_ext[SIXTHS_W-1:0];
        out_data_q[TRIPLES_LSB +: TRIPLES_W] <= tri_ext[TRIPLES_W-1:0];
      end
      out_data_q[EMPTY_LSB] <= empty;
      out_data_q[OVF_LSB]   <= drop_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------- status ----------------
  assign sts_o.empty     = empty;
  assign sts_o.scan_done = scan_done;
  assign sts_o.last_y    = (j_q == (n2_q - CNT_W'(1)));
  assign sts_o.div_done  = (dcnt_q == DC_W'(1));
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

endmodule

`default_nettype wire

[rtl/core/empirical_vus_three_class_core.sv]
// ----------------------------------------------------------------------------
// empirical_vus_three_class_core - empirical three-class VUS engine
// Clear and load items leave the controller idle and may follow back to back.
// Reset clears the group counts, drop flag and controller; no memory sweep.
// ----------------------------------------------------------------------------
`default_nettype none
`include "empirical_vus_three_class_core_assert.svh"

// Operation
//   Each input item carries an action in tuser. A clear resets the three
//   group counts and the drop flag. A load appends the score to its group's
//   store, or sets the drop flag when the group is already full. A compute
//   walks every group two score y; for each one it scans groups one and three
//   in parallel, one entry of each per cycle, counting scores below, equal to
//   and above y. Four small products of those tallies are registered and then
//   folded into the running sum of sixths. A restoring divider then produces
//   the fraction floor(sixths * 2^FRACTION_BITS / (6 * triples)), one bit per
//   cycle.
//
// Timing
//   The scan over groups one and three sets the compute time: each group two
//   score passes through a read-issue state, the scan, a multiply state and
//   an accumulate state. The triple count is formed in the TRIP_A and TRIP_B
//   states; the divider runs after the last score. The result sits in an
//   output register, so new items are taken while it waits to be read; a
//   second compute holds in its final state until that register is free.
//
// Reset
//   The score stores are never cleared; only entries below a group's count
//   are read.
module empirical_vus_three_class_core #(
  parameter int unsigned MAX_PER_GROUP = 256,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Input stream.
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // tdata: score [31:0].
  input  wire logic [evtc_pkg::SCORE_W-1:0]        s_axis_tdata_i,
  // tuser: action [1:0], group [3:2].
  input  wire logic [evtc_pkg::IN_TUSER_W-1:0]     s_axis_tuser_i,
  // Result stream.
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // tdata: vus_fraction [16:0], weighted_sixths [43:17], triple_count [68:44],
  //        empty_error [69], overflow_flag [70], zero [71].
  output logic      [evtc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);
  import evtc_pkg::*;

  cmd_t    cmd;
  sts_t    sts;
  action_e action;
  logic [GROUP_W-1:0] group;

  // Split the side-band into the action and the target group.
  assign action = action_e'(s_axis_tuser_i[ACTION_W-1:0]);
  assign group  = s_axis_tuser_i[ACTION_W +: GROUP_W];

  // The controller accepts items only while idle.
  assign s_axis_tready_o = cmd.in_ready;

  evtc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .action_i   (action),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  evtc_dp #(
    .MAX_PER_GROUP (MAX_PER_GROUP),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_valid_i  (s_axis_tvalid_i),
    .action_i    (action),
    .group_i     (group),
    .score_i     (s_axis_tdata_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o)
  );

  // A result appears only after the controller's finish command.
  `EVTC_ASSERT_NEXT(a_valid_needs_finish, clk_i, rst_ni, !m_axis_tvalid_o && !cmd.finish, !m_axis_tvalid_o, "result valid without finish")

  // No item may be taken while the scan or the divider is running.
  `EVTC_ASSERT_IMPLY(a_busy_not_ready, clk_i, rst_ni, cmd.scan || cmd.div_step, !s_axis_tready_o, "input accepted during compute")

  // An empty-group result reports zero sums.
  `EVTC_ASSERT_IMPLY(a_empty_zero, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[EMPTY_LSB], m_axis_tdata_o[SIXTHS_LSB +: SIXTHS_W] == '0, "empty result with nonzero sum")

endmodule

`default_nettype wire

[tb/empirical_vus_three_class_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// empirical_vus_three_class_core_tb
// Self-checking bench for the three-class VUS core. A short table of directed
// items goes first, then random clear/load/compute sequences. Every accepted
// item updates a behavioral copy of the score groups. Each compute queues the
// VUS fraction, sixths sum, triple count and flags that the result item must
// carry, and these are compared field by field.
// ----------------------------------------------------------------------------
module empirical_vus_three_class_core_tb;
  import evtc_pkg::*;

  localparam int unsigned MAX_PER_GROUP = 256;
  localparam int unsigned FRACTION_BITS = 16;
  localparam int          CLK_PERIOD    = 20;
  localparam int          RESET_CYCLES  = 12;
  localparam int          TOTAL_ITEMS   = 2000;
  localparam int          HOLD_CYCLES   = 600;
  localparam int          FLUSH_CYCLES  = 100;
  localparam int          MAX_PRINTS    = 50;
  localparam longint      LIMIT_CYCLES  = 2000000;

  // Codes that the package leaves unnamed but the stimulus must reach.
  localparam logic [ACTION_W-1:0] ACT_BAD = 2'd3;
  localparam logic [GROUP_W-1:0]  GRP_BAD = 2'd3;

  localparam logic [31:0] SCORE_MIN = 32'h8000_0000;
  localparam logic [31:0] SCORE_MAX = 32'h7FFF_FFFF;

  // Laid out as the low OUT_BITS of the result tdata.
  typedef struct packed {
    logic                 ovf;
    logic                 empty;
    logic [TRIPLES_W-1:0] triples;
    logic [SIXTHS_W-1:0]  sixths;
    logic [VUS_W-1:0]     vus;
  } vus_result_t;

  typedef struct {
    logic [ACTION_W-1:0] act;
    logic [GROUP_W-1:0]  grp;
    logic [SCORE_W-1:0]  score;
    bit                  typed;
    vus_result_t         exp;
  } stim_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   s_valid    = 1'b0;
  logic [SCORE_W-1:0]     s_score    = '0;
  logic [IN_TUSER_W-1:0]  s_tuser    = '0;
  logic                   s_ready;
  logic                   m_valid;
  logic                   rslt_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // Behavioral copy of the score groups.
  int          grp_scores [3][MAX_PER_GROUP];
  int unsigned grp_fill [3];
  bit          drop_seen;

  vus_result_t vus_results_q [$];
  stim_row_t   dir_rows [$];
  int          mismatch_count = 0;
  int          counted_items  = 0;
  int          burst_left     = 0;
  int          gap_max        = 12;
  bit          hold_req       = 1'b0;

  empirical_vus_three_class_core #(
    .MAX_PER_GROUP(MAX_PER_GROUP),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_score),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(rslt_ready),
    .m_axis_tdata_o (m_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Mismatches found");
    $finish;
  end

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    if (mismatch_count < MAX_PRINTS) begin
      $display("ERROR @%0t %s: got %0d, want %0d", $realtime, field, got, want);
    end
    mismatch_count++;
  endtask

  // Weighs every triple the way the core should and forms the result item.
  function automatic vus_result_t tally_vus();
    vus_result_t     r;
    longint unsigned n1, n2, n3, triples, sixths, lt, eqx, gt, eqz, frac;
    int              y;
    r       = '0;
    r.ovf   = drop_seen;
    n1      = grp_fill[0];
    n2      = grp_fill[1];
    n3      = grp_fill[2];
    if (n1 == 0 || n2 == 0 || n3 == 0) begin
      r.empty = 1'b1;
      return r;
    end
    triples = n1 * n2 * n3;
    sixths  = 0;
    for (int j = 0; j < n2; j++) begin
      y   = grp_scores[1][j];
      lt  = 0;
      eqx = 0;
      gt  = 0;
      eqz = 0;
      for (int i = 0; i < n1; i++) begin
        if (grp_scores[0][i] < y) lt++;
        else if (grp_scores[0][i] == y) eqx++;
      end
      for (int i = 0; i < n3; i++) begin
        if (grp_scores[2][i] > y) gt++;
        else if (grp_scores[2][i] == y) eqz++;
      end
      sixths += 6 * lt * gt + 3 * (eqx * gt + lt * eqz) + eqx * eqz;
    end
    frac      = (sixths << FRACTION_BITS) / (6 * triples);
    r.vus     = frac[VUS_W-1:0];
    r.sixths  = sixths[SIXTHS_W-1:0];
    r.triples = triples[TRIPLES_W-1:0];
    return r;
  endfunction

  function automatic void apply_item(input logic [ACTION_W-1:0] act,
                                     input logic [GROUP_W-1:0] grp,
                                     input logic [SCORE_W-1:0] score,
                                     output bit has_res, output vus_result_t res);
    has_res = 1'b0;
    res     = '0;
    case (act)
      ACT_CLEAR: begin
        grp_fill  = '{0, 0, 0};
        drop_seen = 1'b0;
      end
      ACT_LOAD: begin
        if (grp != GRP_BAD) begin
          if (grp_fill[grp] >= MAX_PER_GROUP) begin
            drop_seen = 1'b1;
          end else begin
            grp_scores[grp][grp_fill[grp]] = score;
            grp_fill[grp]++;
          end
        end
      end
      ACT_COMPUTE: begin
        has_res = 1'b1;
        res     = tally_vus();
      end
      default: ;
    endcase
  endfunction

  // Offers one item from a falling edge, waits for the handshake, predicts,
  // and then may open a random gap when the current burst runs out.
  task automatic send_item(logic [ACTION_W-1:0] act, logic [GROUP_W-1:0] grp,
                           logic [SCORE_W-1:0] score, bit typed, vus_result_t exp);
    bit          has_res;
    vus_result_t res;
    s_valid <= 1'b1;
    s_score <= score;
    s_tuser <= {grp, act};
    do @(posedge clk); while (!s_ready);
    if (act != ACT_BAD && !(act == ACT_LOAD && grp == GRP_BAD)) counted_items++;
    apply_item(act, grp, score, has_res, res);
    if (has_res) vus_results_q.push_back(typed ? exp : res);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gap_max > 0 && $urandom_range(0, 3) != 0) begin
        s_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk);
      end
    end
  endtask

  task automatic drain_results();
    s_valid <= 1'b0;
    while (vus_results_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic row(logic [ACTION_W-1:0] act, logic [GROUP_W-1:0] grp,
                     logic [SCORE_W-1:0] score, int typed, int vus, int sixths,
                     int triples, int empty, int ovf);
    stim_row_t r;
    r.act   = act;
    r.grp   = grp;
    r.score = score;
    r.typed = (typed != 0);
    r.exp   = {1'(ovf), 1'(empty), TRIPLES_W'(triples), SIXTHS_W'(sixths),
               VUS_W'(vus)};
    dir_rows.push_back(r);
  endtask

  // Mostly near-ties around the sequence base, some full-range values and
  // some extremes.
  function automatic logic [SCORE_W-1:0] pick_score(logic [SCORE_W-1:0] base);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return base + $urandom_range(0, 4);
    if (pick < 8) return $urandom;
    case ($urandom_range(0, 3))
      0:       return SCORE_MIN;
      1:       return SCORE_MAX;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic int unsigned pick_count();
    return ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 6);
  endfunction

  task automatic send_noise();
    if ($urandom_range(0, 1) == 0) begin
      send_item(ACT_BAD, 2'($urandom_range(0, 3)), $urandom, 1'b0, '0);
    end else begin
      send_item(ACT_LOAD, GRP_BAD, $urandom, 1'b0, '0);
    end
  endtask

  // Optional clear, the requested loads in random order with some noise,
  // then one compute and sometimes a second one straight behind it.
  task automatic fill_and_compute(int unsigned n0, int unsigned n1, int unsigned n2,
                                  bit with_clear);
    int unsigned       left [3];
    int unsigned       g;
    logic [SCORE_W-1:0] base;
    left = '{n0, n1, n2};
    base = $urandom;
    if (with_clear) send_item(ACT_CLEAR, 2'($urandom_range(0, 3)), $urandom, 1'b0, '0);
    while (left[0] + left[1] + left[2] != 0) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      g = $urandom_range(0, 2);
      if (left[g] != 0) begin
        send_item(ACT_LOAD, 2'(g), pick_score(base), 1'b0, '0);
        left[g]--;
      end
    end
    send_item(ACT_COMPUTE, 2'($urandom_range(0, 3)), $urandom, 1'b0, '0);
    if ($urandom_range(0, 6) == 0) begin
      send_item(ACT_COMPUTE, 2'($urandom_range(0, 3)), $urandom, 1'b0, '0);
    end
  endtask

  // Result side: a long hold-off on request, otherwise stretches of steady,
  // random or mostly stalled ready.
  initial begin
    int unsigned stretch_left;
    int unsigned mode;
    stretch_left = 0;
    mode         = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rslt_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (stretch_left == 0) begin
          mode         = $urandom_range(0, 2);
          stretch_left = $urandom_range(10, 150);
        end
        stretch_left--;
        case (mode)
          0:       rslt_ready <= 1'b1;
          1:       rslt_ready <= 1'($urandom_range(0, 1));
          default: rslt_ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    vus_result_t got;
    vus_result_t want;
    if (rst_n && m_valid && rslt_ready) begin
      got = m_tdata[OUT_BITS-1:0];
      if (vus_results_q.size() == 0) begin
        report("result with nothing expected", 64'(got), 64'(0));
      end else begin
        want = vus_results_q.pop_front();
        if (got.vus !== want.vus)
          report("vus_fraction", 64'(got.vus), 64'(want.vus));
        if (got.sixths !== want.sixths)
          report("weighted_sixths", 64'(got.sixths), 64'(want.sixths));
        if (got.triples !== want.triples)
          report("triple_count", 64'(got.triples), 64'(want.triples));
        if (got.empty !== want.empty)
          report("empty_error", 64'(got.empty), 64'(want.empty));
        if (got.ovf !== want.ovf)
          report("overflow_flag", 64'(got.ovf), 64'(want.ovf));
      end
    end
  end

  initial begin
    bit fill_one_done;
    bit all_full_done;
    bit pressure_done;
    fill_one_done = 1'b0;
    all_full_done = 1'b0;
    pressure_done = 1'b0;
    grp_fill      = '{0, 0, 0};
    drop_seen     = 1'b0;

    // Empty groups at reset, ignored codes, lone extremes, ties and an
    // unordered triple. Rows with typed expectations need no predictor.
    row(ACT_COMPUTE, GRP_ONE,   '0,            1, 0,     0, 0, 1, 0);
    row(ACT_BAD,     GRP_BAD,   '1,            0, 0,     0, 0, 0, 0);
    row(ACT_LOAD,    GRP_BAD,   32'h1234_5678, 0, 0,     0, 0, 0, 0);
    row(ACT_COMPUTE, GRP_BAD,   '0,            1, 0,     0, 0, 1, 0);
    row(ACT_LOAD,    GRP_ONE,   SCORE_MIN,     0, 0,     0, 0, 0, 0);
    row(ACT_LOAD,    GRP_TWO,   '0,            0, 0,     0, 0, 0, 0);
    row(ACT_LOAD,    GRP_THREE, SCORE_MAX,     0, 0,     0, 0, 0, 0);
    row(ACT_COMPUTE, GRP_TWO,   '0,            1, 65536, 6, 1, 0, 0);
    row(ACT_LOAD,    GRP_ONE,   SCORE_MAX,     0, 0,     0, 0, 0, 0);
    row(ACT_COMPUTE, GRP_THREE, '1,            0, 0,     0, 0, 0, 0);
    row(ACT_LOAD,    GRP_THREE, SCORE_MIN,     0, 0,     0, 0, 0, 0);
    row(ACT_COMPUTE, GRP_ONE,   '0,            0, 0,     0, 0, 0, 0);
    row(ACT_CLEAR,   GRP_BAD,   32'hA5A5_5A5A, 0, 0,     0, 0, 0, 0);
    row(ACT_COMPUTE, GRP_ONE,   '0,            1, 0,     0, 0, 1, 0);
    row(ACT_LOAD,    GRP_ONE,   '1,            0, 0,     0, 0, 0, 0);
    row(ACT_LOAD,    GRP_TWO,   '1,            0, 0,     0, 0, 0, 0);
    row(ACT_LOAD,    GRP_THREE, '1,            0, 0,     0, 0, 0, 0);
    row(ACT_COMPUTE, GRP_ONE,   '0,            1, 10922, 1, 1, 0, 0);
    row(ACT_LOAD,    GRP_THREE, '0,            0, 0,     0, 0, 0, 0);
    row(ACT_LOAD,    GRP_ONE,   32'hFFFF_FFFE, 0, 0,     0, 0, 0, 0);
    row(ACT_COMPUTE, GRP_TWO,   '0,            0, 0,     0, 0, 0, 0);
    row(ACT_CLEAR,   GRP_ONE,   '0,            0, 0,     0, 0, 0, 0);
    row(ACT_LOAD,    GRP_ONE,   32'd3,         0, 0,     0, 0, 0, 0);
    row(ACT_LOAD,    GRP_TWO,   32'd2,         0, 0,     0, 0, 0, 0);
    row(ACT_LOAD,    GRP_THREE, 32'd1,         0, 0,     0, 0, 0, 0);
    row(ACT_COMPUTE, GRP_ONE,   '0,            1, 0,     0, 1, 0, 0);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[k]) begin
      send_item(dir_rows[k].act, dir_rows[k].grp, dir_rows[k].score,
                dir_rows[k].typed, dir_rows[k].exp);
    end
    drain_results();

    while (counted_items < TOTAL_ITEMS) begin
      if (!fill_one_done && counted_items > 300) begin
        // One group runs full and keeps receiving loads, so the drop flag
        // must show on every compute behind it.
        fill_one_done = 1'b1;
        case ($urandom_range(0, 2))
          0:       fill_and_compute(MAX_PER_GROUP + 3, 2, 3, 1'b1);
          1:       fill_and_compute(2, MAX_PER_GROUP + 2, 3, 1'b1);
          default: fill_and_compute(3, 2, MAX_PER_GROUP + 1, 1'b1);
        endcase
        send_item(ACT_COMPUTE, GRP_ONE, '0, 1'b0, '0);
      end else if (!pressure_done && counted_items > 600) begin
        // The result side stops for a long stretch while items keep coming
        // without gaps, so the output register fills and the input
        // stalls. Afterwards the sender waits for every result.
        pressure_done = 1'b1;
        gap_max       = 0;
        hold_req      = 1'b1;
        repeat (4) fill_and_compute($urandom_range(1, 3), $urandom_range(1, 3),
                                    $urandom_range(1, 3), 1'b1);
        gap_max = 12;
        drain_results();
      end else if (!all_full_done && counted_items > 1000) begin
        // All groups full and strictly ordered between groups: the largest
        // triple count and sixths sum, a full-scale fraction and one drop.
        all_full_done = 1'b1;
        send_item(ACT_CLEAR, GRP_ONE, '0, 1'b0, '0);
        for (int g = 0; g < 3; g++) begin
          for (int k = 0; k < MAX_PER_GROUP + (g == 1); k++) begin
            case (g)
              0:       send_item(ACT_LOAD, GRP_ONE,
                                 SCORE_MIN + $urandom_range(0, 32'd2147482648), 1'b0, '0);
              1:       send_item(ACT_LOAD, GRP_TWO,
                                 32'($urandom_range(0, 1998)) - 32'd999, 1'b0, '0);
              default: send_item(ACT_LOAD, GRP_THREE,
                                 32'd1000 + $urandom_range(0, 32'd2147482647), 1'b0, '0);
            endcase
          end
        end
        send_item(ACT_COMPUTE, 2'($urandom_range(0, 3)), $urandom, 1'b0, '0);
      end else if ($urandom_range(0, 99) < 85) begin
        // Clear mostly, and always once a group grows past ten, so computes stay short.
        fill_and_compute(pick_count(), pick_count(), pick_count(),
                         ($urandom_range(0, 3) != 0) || grp_fill[0] > 10 ||
                         grp_fill[1] > 10 || grp_fill[2] > 10);
      end else begin
        repeat ($urandom_range(1, 4)) send_noise();
      end
    end

    drain_results();
    repeat (FLUSH_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[empirical_vus_three_class_core.f]
+incdir+rtl/core
rtl/core/evtc_pkg.sv
rtl/core/evtc_ram.sv
rtl/core/evtc_ctrl.sv
rtl/core/evtc_dp.sv
rtl/core/empirical_vus_three_class_core.sv
tb/empirical_vus_three_class_core_tb.sv
